[rtl/core/tcce_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants for the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int IDX_W  = 11;
    localparam int POS_W  = 11;
    localparam int CELL_W = 16;
    localparam int IN_W   = 24;   // char_code + cell_index, padded to bytes
    localparam int OUT_W  = 32;   // cursor_pos + cell_data, padded to bytes

    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int TAB_STEP = 4;

    localparam logic [CELL_W-1:0] CELL_RESET = 16'h0720;
    localparam logic [7:0]        COLOR_RESET = 8'h07;

    typedef struct packed {
        logic       wr_en;
        logic [7:0] wr_char;
        logic       scroll;
    } t_put;

endpackage

[rtl/core/tcce_cursor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_cursor
// Cursor row/column tracking and put-character decode. Keeps the row base
// address so the cell address needs one add, no multiply.
// ----------------------------------------------------------------------------
module tcce_cursor
    import tcce_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    localparam int AW     = $clog2(ROWS * COLUMNS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic          i_home,
    input  logic [7:0]    i_char,
    output t_put          o_put,
    output logic [AW-1:0] o_wr_addr,
    output logic [AW-1:0] o_pos
);

    localparam int CW = $clog2(COLUMNS + TAB_STEP);
    localparam int RW = $clog2(ROWS);

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [AW-1:0] r_base, n_base;
    logic [CW-1:0] w_wr_col;
    logic          w_inc;

    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_base   = r_base;
        w_inc    = 1'b0;
        w_wr_col = r_col;
        o_put    = '0;
        case (i_char)
            CH_LF: begin
                n_col = '0;
                w_inc = 1'b1;
            end
            CH_CR: begin
                n_col = '0;
            end
            CH_TAB: begin
                n_col = (r_col + CW'(TAB_STEP)) & ~CW'(TAB_STEP - 1);
            end
            CH_BS: begin
                if (r_col != '0) begin
                    n_col         = r_col - 1'b1;
                    w_wr_col      = r_col - 1'b1;
                    o_put.wr_en   = 1'b1;
                    o_put.wr_char = CH_SPACE;
                end
            end
            default: begin
                n_col         = r_col + 1'b1;
                o_put.wr_en   = 1'b1;
                o_put.wr_char = i_char;
            end
        endcase
        if (n_col >= CW'(COLUMNS)) begin
            n_col = '0;
            w_inc = 1'b1;
        end
        if (w_inc) begin
            if (r_row == RW'(ROWS - 1)) begin
                o_put.scroll = 1'b1;
            end else begin
                n_row  = r_row + 1'b1;
                n_base = r_base + AW'(COLUMNS);
            end
        end
    end

    assign o_wr_addr = r_base + AW'(w_wr_col);
    assign o_pos     = r_base + AW'(r_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_home) begin
            r_col  <= '0;
            r_row  <= '0;
            r_base <= '0;
        end else if (i_step) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_base <= n_base;
        end
    end

endmodule

[rtl/core/text_console_cursor_engine_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_engine_unit
// Text console engine: ROWS x COLUMNS cell store, cursor, put/clear/read.
// ----------------------------------------------------------------------------
// channel   dir  handshake                     word
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tuser=action, tdata=char,index
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata=cursor_pos,cell_data
// cfg       in   i_cfg_we                      i_cfg_wdata=text_color
//
// Put character: S_EXEC, then S_DONE; read: S_EXEC, S_READ, S_DONE.
// A put that scrolls moves each row up in S_COPY/S_CEND and fills the last
// row in S_FILL, one cell copied or filled per cycle through the single
// write port. Clear: S_FILL over every cell. After reset a fill pass over
// every cell runs with tready low. One word at a time; a result waiting in
// the output register does not block acceptance of the next word.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_unit
    import tcce_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [IN_W-1:0]  i_s_axis_tdata,   // [7:0] char_code, [18:8] cell_index
    input  logic [1:0]       i_s_axis_tuser,   // [1:0] action
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata,   // [10:0] cursor_pos, [26:11] cell_data
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int AW         = $clog2(CELL_COUNT);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_COPY = 3'd4;
    localparam logic [2:0] S_CEND = 3'd5;
    localparam logic [2:0] S_FILL = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [7:0]        r_color;
    logic [1:0]        r_act;
    logic [7:0]        r_char;
    logic [IDX_W-1:0]  r_idx;
    logic [AW-1:0]     r_dst, n_dst;
    logic [AW-1:0]     r_src, n_src;
    logic [AW-1:0]     r_wr_a;
    logic              r_pend, n_pend;
    logic [CELL_W-1:0] r_data, n_data;
    logic [CELL_W-1:0] r_rd_data;
    logic              r_ovalid;
    logic [OUT_W-1:0]  r_odata;
    logic [CELL_W-1:0] r_mem [CELL_COUNT];

    logic              w_accept;
    logic              w_step;
    logic              w_home;
    t_put              w_put;
    logic [AW-1:0]     w_put_addr;
    logic [AW-1:0]     w_pos;
    logic              w_idx_ok;
    logic [AW+IDX_W-1:0] w_idx_wide;
    logic [AW+POS_W-1:0] w_pos_wide;
    logic              w_we;
    logic [AW-1:0]     w_wa;
    logic [CELL_W-1:0] w_wd;
    logic              w_re;
    logic [AW-1:0]     w_ra;
    logic              w_load;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_step          = (r_state == S_EXEC) && (r_act == ACT_PUT);
    assign w_home          = (r_state == S_EXEC) && (r_act == ACT_CLEAR);
    assign w_idx_ok        = (32'(r_idx) < 32'(CELL_COUNT));
    assign w_idx_wide      = (AW + IDX_W)'(r_idx);
    assign w_pos_wide      = (AW + POS_W)'(w_pos);
    assign w_load          = (r_state == S_DONE) && (!r_ovalid || i_m_axis_tready);

    tcce_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_home    (w_home),
        .i_char    (r_char),
        .o_put     (w_put),
        .o_wr_addr (w_put_addr),
        .o_pos     (w_pos)
    );

    always_comb begin
        n_state = r_state;
        n_dst   = r_dst;
        n_src   = r_src;
        n_pend  = r_pend;
        n_data  = r_data;
        w_we    = 1'b0;
        w_wa    = r_dst;
        w_wd    = {r_color, CH_SPACE};
        w_re    = 1'b0;
        w_ra    = r_src;
        unique case (r_state)
            S_INIT: begin
                w_we  = 1'b1;
                w_wd  = CELL_RESET;
                n_dst = r_dst + 1'b1;
                if (r_dst == AW'(CELL_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_data = '0;
                case (r_act)
                    ACT_PUT: begin
                        w_we = w_put.wr_en;
                        w_wa = w_put_addr;
                        w_wd = {r_color, w_put.wr_char};
                        if (w_put.scroll) begin
                            n_dst   = '0;
                            n_src   = AW'(COLUMNS);
                            n_pend  = 1'b0;
                            n_state = S_COPY;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    ACT_CLEAR: begin
                        n_dst   = '0;
                        n_state = S_FILL;
                    end
                    ACT_READ: begin
                        if (w_idx_ok) begin
                            w_re    = 1'b1;
                            w_ra    = w_idx_wide[AW-1:0];
                            n_state = S_READ;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_READ: begin
                n_data  = r_rd_data;
                n_state = S_DONE;
            end
            S_COPY: begin
                w_re   = 1'b1;
                w_ra   = r_src;
                w_we   = r_pend;
                w_wa   = r_wr_a;
                w_wd   = r_rd_data;
                n_pend = 1'b1;
                n_dst  = r_dst + 1'b1;
                n_src  = r_src + 1'b1;
                if (r_src == AW'(CELL_COUNT - 1)) begin
                    n_state = S_CEND;
                end
            end
            S_CEND: begin
                w_we    = 1'b1;
                w_wa    = r_wr_a;
                w_wd    = r_rd_data;
                n_pend  = 1'b0;
                n_state = S_FILL;
            end
            S_FILL: begin
                w_we  = 1'b1;
                n_dst = r_dst + 1'b1;
                if (r_dst == AW'(CELL_COUNT - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_dst    <= '0;
            r_src    <= '0;
            r_pend   <= 1'b0;
            r_color  <= COLOR_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dst   <= n_dst;
            r_src   <= n_src;
            r_pend  <= n_pend;
            if (i_cfg_we) begin
                r_color <= i_cfg_wdata;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act  <= i_s_axis_tuser;
            r_char <= i_s_axis_tdata[7:0];
            r_idx  <= i_s_axis_tdata[8 +: IDX_W];
        end
        r_data <= n_data;
        r_wr_a <= r_dst;
        if (w_load) begin
            r_odata <= {(OUT_W - POS_W - CELL_W)'(0), r_data, w_pos_wide[POS_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_ra];
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

endmodule

[rtl/core/tcce_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_checker
// Port-level checks for the text console cursor engine, bound to the top.
// ----------------------------------------------------------------------------
module tcce_checker
    import tcce_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_axis_tvalid,
    input logic             o_s_axis_tready,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata
);

    localparam int CELL_COUNT = ROWS * COLUMNS;

    // output word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output word dropped or changed under stall");

    // one word at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("ready right after accept");

    // store fill runs after reset
    a_rst_fill: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("ready during post-reset fill");

    // cursor stays on screen
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (CELL_COUNT > 2048) ||
            (32'(o_m_axis_tdata[POS_W-1:0]) < 32'(CELL_COUNT)))
        else $error("cursor position off screen");

    // padding bits are zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[OUT_W-1:POS_W+CELL_W] == '0)
        else $error("nonzero pad bits");

endmodule

bind text_console_cursor_engine_unit tcce_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcce_checker (.*);

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for text_console_cursor_engine_unit. A shadow console
// (cell store, cursor, text colour) predicts the cursor position and cell
// data for every accepted word. Directed words cover the control bytes, the
// extreme bytes, reads past the screen, the unused action, clear, line wrap
// and scroll. Structured random text and reads follow under three idle
// patterns. A long receiver hold-off fills the block. The text colour is
// rewritten only while the block is drained.
// ----------------------------------------------------------------------------
module tb;
    import tcce_pkg::*;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELLS       = COLUMNS * ROWS;
    localparam int STALL_LIMIT = 20000;
    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [CELL_W-1:0] data;
    } t_result;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata   = '0;
    logic [1:0]       s_tuser   = '0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_we    = 1'b0;
    logic [7:0]       cfg_wdata = '0;

    // shadow console
    logic [CELL_W-1:0] screen_shadow [CELLS];
    int unsigned       cur_row = 0;
    int unsigned       cur_col = 0;
    logic [7:0]        text_color = COLOR_RESET;

    t_result pending_results[$];
    int      mismatches     = 0;
    int      quiet_cycles   = 0;
    int      send_idle_pct  = 0;
    int      recv_idle_pct  = 0;
    int      rx_hold_cycles = 0;

    text_console_cursor_engine_unit #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic t_result console_step(input logic [1:0] action, input logic [7:0] ch,
                                             input logic [IDX_W-1:0] idx);
        t_result r;
        r.data = '0;
        case (action)
            ACT_PUT: begin
                case (ch)
                    CH_LF: begin
                        cur_col = 0;
                        cur_row++;
                    end
                    CH_CR: cur_col = 0;
                    CH_TAB: cur_col = (cur_col + TAB_STEP) / TAB_STEP * TAB_STEP;
                    CH_BS: begin
                        if (cur_col > 0) begin
                            cur_col--;
                            screen_shadow[cur_row * COLUMNS + cur_col] = {text_color, CH_SPACE};
                        end
                    end
                    default: begin
                        screen_shadow[cur_row * COLUMNS + cur_col] = {text_color, ch};
                        cur_col++;
                    end
                endcase
                if (cur_col >= COLUMNS) begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= ROWS) begin
                    for (int i = 0; i < CELLS - COLUMNS; i++)
                        screen_shadow[i] = screen_shadow[i + COLUMNS];
                    for (int i = CELLS - COLUMNS; i < CELLS; i++)
                        screen_shadow[i] = {text_color, CH_SPACE};
                    cur_row = ROWS - 1;
                end
            end
            ACT_CLEAR: begin
                for (int i = 0; i < CELLS; i++)
                    screen_shadow[i] = {text_color, CH_SPACE};
                cur_row = 0;
                cur_col = 0;
            end
            ACT_READ: begin
                if (idx < CELLS)
                    r.data = screen_shadow[idx];
            end
            default: ;
        endcase
        r.pos = POS_W'(cur_row * COLUMNS + cur_col);
        return r;
    endfunction

    task automatic send_word(input logic [1:0] action, input logic [7:0] ch,
                             input logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= IN_W'({idx, ch});
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_results.push_back(console_step(action, ch, idx));
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic set_text_color(input logic [7:0] color);
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= color;
        @(posedge clk);
        cfg_we    <= 1'b0;
        text_color = color;
    endtask

    task automatic test_directed();
        send_word(ACT_PUT, 8'h41, '0);
        send_word(ACT_PUT, 8'h00, '1);
        send_word(ACT_PUT, 8'hFF, '0);
        send_word(ACT_PUT, CH_TAB, '0);
        send_word(ACT_PUT, CH_BS, '0);
        send_word(ACT_PUT, CH_TAB, '0);
        send_word(ACT_PUT, CH_TAB, '0);
        for (int i = 0; i < 5; i++)
            send_word(ACT_READ, 8'hFF, IDX_W'(i));
        send_word(ACT_PUT, CH_CR, '0);
        send_word(ACT_PUT, CH_BS, '0);      // column 0: no effect
        send_word(ACT_PUT, CH_LF, '0);
        send_word(ACT_PUT, 8'h7F, '0);
        send_word(ACT_READ, '0, IDX_W'(COLUMNS));
        send_word(ACT_READ, '0, IDX_W'(CELLS - 1));
        send_word(ACT_READ, '0, IDX_W'(CELLS));
        send_word(ACT_READ, '0, '1);
        send_word(ACT_NONE, '1, '1);
        send_word(ACT_CLEAR, 8'h41, IDX_W'(5));
        send_word(ACT_READ, '0, '0);
    endtask

    task automatic test_text_color();
        logic [7:0] colors [3];
        colors[0] = 8'h00;
        colors[1] = 8'hFF;
        colors[2] = 8'($urandom);
        foreach (colors[k]) begin
            set_text_color(colors[k]);
            send_word(ACT_PUT, 8'h5A, IDX_W'($urandom));
            send_word(ACT_PUT, 8'h61, IDX_W'($urandom));
            send_word(ACT_PUT, CH_BS, IDX_W'($urandom));
            send_word(ACT_READ, 8'($urandom), IDX_W'(cur_row * COLUMNS + cur_col - 1));
            send_word(ACT_READ, 8'($urandom), IDX_W'(cur_row * COLUMNS + cur_col));
        end
        send_word(ACT_CLEAR, 8'($urandom), IDX_W'($urandom));
        send_word(ACT_READ, 8'($urandom), IDX_W'(CELLS / 2));
    endtask

    task automatic test_wrap_scroll();
        send_word(ACT_CLEAR, '0, '0);
        send_word(ACT_PUT, 8'h51, '0);
        repeat (ROWS - 1) send_word(ACT_PUT, CH_LF, IDX_W'($urandom));
        repeat (COLUMNS / TAB_STEP - 1) send_word(ACT_PUT, CH_TAB, IDX_W'($urandom));
        send_word(ACT_PUT, 8'h61, '0);
        send_word(ACT_PUT, 8'h62, '0);
        send_word(ACT_PUT, 8'h63, '0);
        send_word(ACT_PUT, 8'h64, '0);    // last column: wrap, then scroll
        send_word(ACT_READ, '0, '0);
        send_word(ACT_READ, '0, IDX_W'(CELLS - 2 * COLUMNS - 1));
        send_word(ACT_READ, '0, IDX_W'(CELLS - COLUMNS - 4));
        send_word(ACT_READ, '0, IDX_W'(CELLS - COLUMNS - 1));
        send_word(ACT_PUT, 8'h7A, '0);
        send_word(ACT_PUT, CH_LF, '0);    // newline on the last row
        send_word(ACT_READ, '0, IDX_W'(CELLS - 2 * COLUMNS));
        send_word(ACT_READ, '0, IDX_W'(CELLS - COLUMNS));
        send_word(ACT_READ, '0, IDX_W'(CELLS - 1));
    endtask

    task automatic test_random(input int n_words);
        int unsigned target;
        int unsigned at;
        int unsigned back;
        int pick;
        int kind;
        int len;
        logic [IDX_W-1:0] idx;
        target = pending_results.size();
        target = 0;
        while (target < n_words) begin
            kind = $urandom_range(99);
            if (kind < 50) begin
                len = ($urandom_range(99) < 15) ? $urandom_range(60, 110) : $urandom_range(0, 8);
                for (int i = 0; i < len; i++) begin
                    pick = $urandom_range(99);
                    send_word(ACT_PUT, pick < 4 ? CH_TAB : pick < 8 ? CH_BS
                                     : 8'($urandom_range(32, 126)), IDX_W'($urandom));
                end
                target += len;
                pick = $urandom_range(2);
                if (pick == 1) begin
                    send_word(ACT_PUT, CH_CR, IDX_W'($urandom));
                    target++;
                end
                if (pick != 2) begin
                    send_word(ACT_PUT, CH_LF, IDX_W'($urandom));
                    target++;
                end
            end else if (kind < 60) begin
                len = $urandom_range(1, 8);
                repeat (len) send_word(ACT_PUT, CH_LF, IDX_W'($urandom));
                target += len;
            end else if (kind < 85) begin
                len = $urandom_range(1, 6);
                repeat (len) begin
                    at   = cur_row * COLUMNS + cur_col;
                    back = (at < COLUMNS) ? at : COLUMNS;
                    pick = $urandom_range(99);
                    if (pick < 40)
                        idx = IDX_W'(at - $urandom_range(back, 0));
                    else if (pick < 80)
                        idx = IDX_W'($urandom_range(CELLS - 1, 0));
                    else if (pick < 90)
                        idx = IDX_W'($urandom_range(CELLS - 1, CELLS - COLUMNS));
                    else
                        idx = IDX_W'($urandom_range(2 ** IDX_W - 1, CELLS));
                    send_word(ACT_READ, 8'($urandom), idx);
                end
                target += len;
            end else if (kind < 92) begin
                send_word(ACT_PUT, 8'($urandom), IDX_W'($urandom));
                target++;
            end else if (kind < 98) begin
                len = $urandom_range(1, 4);
                repeat (len) send_word(2'($urandom), 8'($urandom), IDX_W'($urandom));
                target += len;
            end else begin
                send_word(ACT_CLEAR, 8'($urandom), IDX_W'($urandom));
                target++;
            end
        end
    endtask

    task automatic test_backpressure();
        wait_drain();
        rx_hold_cycles = 400;
        for (int i = 0; i < 40; i++) begin
            if (i % 4 == 3)
                send_word(ACT_READ, 8'($urandom), IDX_W'(cur_row * COLUMNS + cur_col - 1));
            else
                send_word(ACT_PUT, 8'($urandom_range(33, 126)), IDX_W'($urandom));
        end
        wait_drain();
        repeat (10) send_word(ACT_READ, 8'($urandom), IDX_W'($urandom_range(CELLS - 1, 0)));
    endtask

    // receiver: random stalls plus an occasional long hold-off
    initial begin
        forever begin
            @(posedge clk);
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                rx_hold_cycles--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk) begin : check_results
        t_result exp_r;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result word %h", $time, m_tdata);
            end else begin
                exp_r = pending_results.pop_front();
                if (m_tdata[POS_W-1:0] !== exp_r.pos
                        || m_tdata[POS_W +: CELL_W] !== exp_r.data) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: expected pos %0d data %h, got pos %0d data %h",
                                 $time, exp_r.pos, exp_r.data,
                                 m_tdata[POS_W-1:0], m_tdata[POS_W +: CELL_W]);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("text_console_cursor_engine_unit test failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < CELLS; i++)
            screen_shadow[i] = CELL_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 11;
        recv_idle_pct = 59;
        test_directed();
        test_text_color();
        test_wrap_scroll();
        test_random(220);

        set_text_color(8'($urandom));
        send_idle_pct = 59;
        recv_idle_pct = 11;
        test_random(220);

        set_text_color(8'($urandom));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(220);

        wait_drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("text_console_cursor_engine_unit test passed");
        else
            $display("text_console_cursor_engine_unit test failed");
        $finish;
    end

endmodule
